[sv/rru_pkg.sv]
// Shared constants, command codes and control types for the rational reconstruction unit.
package rru_pkg;

  localparam int DefaultValueWidth = 63;
  localparam int FieldWidth = 63;
  localparam int BoundWidth = 31;
  localparam int NumWidth = 32;
  localparam int DenWidth = 31;
  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] REG_MODULUS = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_BOUND = 2'd1;

  localparam int OpWidth = 5;
  localparam logic [OpWidth-1:0] OP_NONE      = 5'd0;
  localparam logic [OpWidth-1:0] OP_RED       = 5'd1;
  localparam logic [OpWidth-1:0] OP_EUC_INIT  = 5'd2;
  localparam logic [OpWidth-1:0] OP_EUC_DIV   = 5'd3;
  localparam logic [OpWidth-1:0] OP_EUC_STEP  = 5'd4;
  localparam logic [OpWidth-1:0] OP_SIGN      = 5'd5;
  localparam logic [OpWidth-1:0] OP_GCD_DIV   = 5'd6;
  localparam logic [OpWidth-1:0] OP_GCD_STEP  = 5'd7;
  localparam logic [OpWidth-1:0] OP_DIV_NM    = 5'd8;
  localparam logic [OpWidth-1:0] OP_DIV_DM    = 5'd9;
  localparam logic [OpWidth-1:0] OP_SET_DM    = 5'd10;
  localparam logic [OpWidth-1:0] OP_GCD2_INIT = 5'd11;
  localparam logic [OpWidth-1:0] OP_MUL_INIT  = 5'd12;
  localparam logic [OpWidth-1:0] OP_MUL_STEP  = 5'd13;
  localparam logic [OpWidth-1:0] OP_LHS_DIV   = 5'd14;
  localparam logic [OpWidth-1:0] OP_OK        = 5'd15;
  localparam logic [OpWidth-1:0] OP_FAIL      = 5'd16;
  localparam logic [OpWidth-1:0] OP_EMIT      = 5'd17;

  typedef struct packed {
    logic [OpWidth-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic div_busy;
    logic r1_gt_bound;
    logic t1_zero;
    logic gy_zero;
    logic gx_one;
    logic bound_bad;
    logic my_zero;
    logic check_ok;
    logic out_free;
  } status_t;

endpackage

[sv/rru_in_if.sv]
// Input channel carrying one residue word.
interface rru_in_if;
  logic valid;
  logic ready;
  logic [rru_pkg::FieldWidth-1:0] residue;

  modport source (output valid, output residue, input ready);
  modport sink (input valid, input residue, output ready);
endinterface

[sv/rru_out_if.sv]
// Output channel carrying one reconstructed fraction word.
interface rru_out_if;
  logic valid;
  logic ready;
  logic found;
  logic signed [rru_pkg::NumWidth-1:0] numerator;
  logic [rru_pkg::DenWidth-1:0] denominator;

  modport source (output valid, output found, output numerator, output denominator, input ready);
  modport sink (input valid, input found, input numerator, input denominator, output ready);
endinterface

[sv/rru_ctrl.sv]
// Sequencing state machine for reduction, Euclid, gcd, modular product and checks.
module rru_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rru_pkg::status_t status,
  output rru_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RED       = 4'd1;
  localparam logic [3:0] S_EUC_TEST  = 4'd2;
  localparam logic [3:0] S_EUC_WAIT  = 4'd3;
  localparam logic [3:0] S_GCD_TEST  = 4'd4;
  localparam logic [3:0] S_GCD_WAIT  = 4'd5;
  localparam logic [3:0] S_NM_WAIT   = 4'd6;
  localparam logic [3:0] S_DM_WAIT   = 4'd7;
  localparam logic [3:0] S_BOUND     = 4'd8;
  localparam logic [3:0] S_GCD2_TEST = 4'd9;
  localparam logic [3:0] S_GCD2_WAIT = 4'd10;
  localparam logic [3:0] S_MUL       = 4'd11;
  localparam logic [3:0] S_LHS_WAIT  = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = rru_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (status.m_zero) begin
            cmd.op = rru_pkg::OP_FAIL;
            state_next = S_OUT;
          end else begin
            cmd.op = rru_pkg::OP_RED;
            state_next = S_RED;
          end
        end
      end
      S_RED: begin
        if (!status.div_busy) begin
          cmd.op = rru_pkg::OP_EUC_INIT;
          state_next = S_EUC_TEST;
        end
      end
      S_EUC_TEST: begin
        if (status.r1_gt_bound) begin
          cmd.op = rru_pkg::OP_EUC_DIV;
          state_next = S_EUC_WAIT;
        end else if (status.t1_zero) begin
          cmd.op = rru_pkg::OP_FAIL;
          state_next = S_OUT;
        end else begin
          cmd.op = rru_pkg::OP_SIGN;
          state_next = S_GCD_TEST;
        end
      end
      S_EUC_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = rru_pkg::OP_EUC_STEP;
          state_next = S_EUC_TEST;
        end
      end
      S_GCD_TEST: begin
        if (status.gy_zero) begin
          cmd.op = rru_pkg::OP_DIV_NM;
          state_next = S_NM_WAIT;
        end else begin
          cmd.op = rru_pkg::OP_GCD_DIV;
          state_next = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = rru_pkg::OP_GCD_STEP;
          state_next = S_GCD_TEST;
        end
      end
      S_NM_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = rru_pkg::OP_DIV_DM;
          state_next = S_DM_WAIT;
        end
      end
      S_DM_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = rru_pkg::OP_SET_DM;
          state_next = S_BOUND;
        end
      end
      S_BOUND: begin
        if (status.bound_bad) begin
          cmd.op = rru_pkg::OP_FAIL;
          state_next = S_OUT;
        end else begin
          cmd.op = rru_pkg::OP_GCD2_INIT;
          state_next = S_GCD2_TEST;
        end
      end
      S_GCD2_TEST: begin
        if (!status.gy_zero) begin
          cmd.op = rru_pkg::OP_GCD_DIV;
          state_next = S_GCD2_WAIT;
        end else if (status.gx_one) begin
          cmd.op = rru_pkg::OP_MUL_INIT;
          state_next = S_MUL;
        end else begin
          cmd.op = rru_pkg::OP_FAIL;
          state_next = S_OUT;
        end
      end
      S_GCD2_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = rru_pkg::OP_GCD_STEP;
          state_next = S_GCD2_TEST;
        end
      end
      S_MUL: begin
        if (status.my_zero) begin
          cmd.op = rru_pkg::OP_LHS_DIV;
          state_next = S_LHS_WAIT;
        end else begin
          cmd.op = rru_pkg::OP_MUL_STEP;
        end
      end
      S_LHS_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = status.check_ok ? rru_pkg::OP_OK : rru_pkg::OP_FAIL;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op = rru_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/rru_datapath.sv]
// Datapath: configuration, Euclid registers, shared shift-subtract divider, modular product.
module rru_datapath #(
  parameter int VALUE_WIDTH = rru_pkg::DefaultValueWidth
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rru_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [rru_pkg::FieldWidth-1:0]      cfg_data,
  input  logic [rru_pkg::FieldWidth-1:0]      residue,
  input  rru_pkg::cmd_t                       cmd,
  output rru_pkg::status_t                    status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_found,
  output logic signed [rru_pkg::NumWidth-1:0] out_numerator,
  output logic [rru_pkg::DenWidth-1:0]        out_denominator
);

  localparam int W = VALUE_WIDTH;
  localparam int KW = $clog2(W);
  localparam int BW = rru_pkg::BoundWidth;
  localparam int EW = W + BW;

  logic [W-1:0] m;
  logic [BW-1:0] bound;

  logic [W-1:0] a, r0, r1, nm, dm, gx, gy, acc, mx, my;
  logic [W:0] t0, t1;
  logic neg;

  logic [W-1:0] drem, dden, dquo;
  logic [W:0] dtn, dts;
  logic [KW-1:0] dk;
  logic dalign, dbusy;

  logic res_found;
  logic [rru_pkg::NumWidth-1:0] res_num;
  logic [rru_pkg::DenWidth-1:0] res_den;

  logic div_start;
  logic [W-1:0] div_num, div_den;
  logic [W:0] div_tinit, div_tstep;
  logic [W-1:0] dden_up;
  logic [W:0] ts_shift;
  logic [W:0] t1_abs;
  logic [W-1:0] mul_acc_sum, mul_x_sum;
  logic [W-1:0] lhs_sum;
  logic [EW-1:0] nm_ext, dm_ext;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) begin
      s = s - {1'b0, md};
    end
    return s[W-1:0];
  endfunction

  function automatic logic gt_bound(input logic [W-1:0] v, input logic [BW-1:0] b);
    return {{BW{1'b0}}, v} > {{W{1'b0}}, b};
  endfunction

  assign dden_up = {dden[W-2:0], 1'b0};
  assign ts_shift = dts << dk;
  assign t1_abs = t1[W] ? (~t1 + 1'b1) : t1;
  assign mul_acc_sum = add_mod(acc, mx, m);
  assign mul_x_sum = add_mod(mx, mx, m);
  assign lhs_sum = add_mod(drem, acc, m);
  assign nm_ext = {{BW{1'b0}}, nm};
  assign dm_ext = {{BW{1'b0}}, dm};

  always_comb begin
    div_start = 1'b0;
    div_num = r0;
    div_den = r1;
    div_tinit = t0;
    div_tstep = t1;
    case (cmd.op)
      rru_pkg::OP_RED: begin
        div_start = 1'b1;
        div_num = residue[W-1:0];
        div_den = m;
      end
      rru_pkg::OP_EUC_DIV: begin
        div_start = 1'b1;
      end
      rru_pkg::OP_GCD_DIV: begin
        div_start = 1'b1;
        div_num = gx;
        div_den = gy;
      end
      rru_pkg::OP_DIV_NM: begin
        div_start = 1'b1;
        div_num = nm;
        div_den = gx;
      end
      rru_pkg::OP_DIV_DM: begin
        div_start = 1'b1;
        div_num = dm;
        div_den = gx;
      end
      rru_pkg::OP_LHS_DIV: begin
        div_start = 1'b1;
        div_num = nm;
        div_den = m;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Shift-subtract divider: align the divisor, then subtract one quotient bit per cycle.
  // The cofactor step is subtracted alongside, which yields t0 - q * t1.
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dalign <= 1'b0;
    end else if (div_start) begin
      drem <= div_num;
      dden <= div_den;
      dquo <= '0;
      dk <= '0;
      dtn <= div_tinit;
      dts <= div_tstep;
      dalign <= 1'b1;
      dbusy <= 1'b1;
    end else if (dbusy) begin
      if (dalign) begin
        if (!dden[W-1] && (dden_up <= drem)) begin
          dden <= dden_up;
          dk <= dk + 1'b1;
        end else begin
          dalign <= 1'b0;
        end
      end else begin
        if (dden <= drem) begin
          drem <= drem - dden;
          dquo[dk] <= 1'b1;
          dtn <= dtn - ts_shift;
        end
        if (dk == '0) begin
          dbusy <= 1'b0;
        end else begin
          dk <= dk - 1'b1;
          dden <= {1'b0, dden[W-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m <= W'(2);
      bound <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rru_pkg::REG_MODULUS) begin
        m <= cfg_data[W-1:0];
      end else if (cfg_index == rru_pkg::REG_BOUND) begin
        bound <= cfg_data[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rru_pkg::OP_EUC_INIT: begin
        a <= drem;
        r0 <= m;
        r1 <= drem;
        t0 <= '0;
        t1 <= (W+1)'(1);
      end
      rru_pkg::OP_EUC_STEP: begin
        r0 <= r1;
        r1 <= drem;
        t0 <= t1;
        t1 <= dtn;
      end
      rru_pkg::OP_SIGN: begin
        neg <= t1[W];
        dm <= t1_abs[W-1:0];
        nm <= r1;
        gx <= r1;
        gy <= t1_abs[W-1:0];
      end
      rru_pkg::OP_GCD_STEP: begin
        gx <= gy;
        gy <= drem;
      end
      rru_pkg::OP_DIV_DM: begin
        nm <= dquo;
      end
      rru_pkg::OP_SET_DM: begin
        dm <= dquo;
      end
      rru_pkg::OP_GCD2_INIT: begin
        gx <= dm;
        gy <= m;
      end
      rru_pkg::OP_MUL_INIT: begin
        acc <= '0;
        mx <= a;
        my <= dm;
      end
      rru_pkg::OP_MUL_STEP: begin
        if (my[0]) begin
          acc <= mul_acc_sum;
        end
        mx <= mul_x_sum;
        my <= {1'b0, my[W-1:1]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rru_pkg::OP_OK) begin
      res_found <= 1'b1;
      res_num <= neg ? (~nm_ext[rru_pkg::NumWidth-1:0] + 1'b1) : nm_ext[rru_pkg::NumWidth-1:0];
      res_den <= dm_ext[rru_pkg::DenWidth-1:0];
    end else if (cmd.op == rru_pkg::OP_FAIL) begin
      res_found <= 1'b0;
      res_num <= '0;
      res_den <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == rru_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rru_pkg::OP_EMIT) begin
      out_found <= res_found;
      out_numerator <= res_num;
      out_denominator <= res_den;
    end
  end

  always_comb begin
    status.m_zero = (m == '0);
    status.div_busy = dbusy;
    status.r1_gt_bound = gt_bound(r1, bound);
    status.t1_zero = (t1 == '0);
    status.gy_zero = (gy == '0);
    status.gx_one = (gx == W'(1));
    status.bound_bad = gt_bound(nm, bound) || gt_bound(dm, bound);
    status.my_zero = (my == '0);
    status.check_ok = neg ? (lhs_sum == '0) : (drem == acc);
    status.out_free = !out_valid || out_ready;
  end

endmodule

[sv/rational_reconstruction_unit.sv]
// Top level of the rational reconstruction unit: controller, datapath and channel wiring.
// Each division aligns the divisor by a shift of at most W-1 bits, then subtracts bitwise.
// A word runs one reduction, the Euclid and gcd steps, two divisions by g, a bound check,
// a gcd of denominator and modulus, the modular product and a final numerator division.
// One word is handled at a time; the next is taken in the same cycle its result is output.
// Synchronous reset sets modulus to 2, bound to 0 and returns the controller to idle.
module rational_reconstruction_unit #(
  parameter int VALUE_WIDTH = rru_pkg::DefaultValueWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rru_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [rru_pkg::FieldWidth-1:0]    cfg_data,
  rru_in_if.sink                            in_ch,
  rru_out_if.source                         out_ch
);

  rru_pkg::cmd_t cmd;
  rru_pkg::status_t status;

  rru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rru_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .residue         (in_ch.residue),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_found       (out_ch.found),
    .out_numerator   (out_ch.numerator),
    .out_denominator (out_ch.denominator)
  );

endmodule

[verif/tb_rational_reconstruction_unit.sv]
// Testbench for the rational reconstruction unit: directed table and random residues.
`timescale 1ns / 100ps

module tb_rational_reconstruction_unit;

  localparam int LimitCycles = 10000000;
  localparam logic [62:0] ModMax = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [30:0] BoundMax = 31'h7FFF_FFFF;
  localparam logic [62:0] AllOnes = '1;

  typedef struct packed {
    logic found;
    logic signed [31:0] num;
    logic [30:0] den;
  } fraction_t;

  typedef struct packed {
    logic set_cfg;
    logic [62:0] mod_val;
    logic [30:0] bound_val;
    logic [62:0] residue;
    logic typed;
    fraction_t want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rru_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [rru_pkg::FieldWidth-1:0] cfg_data;

  rru_in_if in_ch ();
  rru_out_if out_ch ();

  rational_reconstruction_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  logic [62:0] cur_mod;
  logic [30:0] cur_bound;
  fraction_t pending_q[$];
  int fails = 0;
  int cycles = 0;
  bit steady = 0;
  bit hold_req = 0;
  int hold_left = 0;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reconstruct(logic [62:0] res);
    fraction_t f;
    logic [63:0] m, bnd, a, r0, r1, t0, t1, q, nr, nt, nm, dm, g, prod, lhs;
    logic [127:0] wide;
    logic neg;
    f = '0;
    m = {1'b0, cur_mod};
    bnd = {33'b0, cur_bound};
    if (m == 0) return f;
    a = {1'b0, res} % m;
    r0 = m;
    r1 = a;
    t0 = 0;
    t1 = 1;
    while (r1 > bnd) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    if (t1 == 0) return f;
    neg = t1[63];
    dm = neg ? -t1 : t1;
    nm = r1;
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm > bnd || dm > bnd || gcd64(dm, m) != 1) return f;
    wide = {64'b0, a} * {64'b0, dm};
    prod = 64'(wide % {64'b0, m});
    lhs = nm % m;
    if (neg ? ((lhs + prod) % m != 0) : (lhs != prod)) return f;
    f.found = 1'b1;
    f.num = neg ? -nm[31:0] : nm[31:0];
    f.den = dm[30:0];
    return f;
  endfunction

  // Inverse of d modulo m, or zero when d and m share a factor.
  function automatic longint mod_inverse(longint d, longint m);
    longint r0, r1, s0, s1, q, tmp;
    r0 = m;
    r1 = d % m;
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = s0 - q * s1;
      s0 = s1;
      s1 = tmp;
    end
    if (r0 != 1) return 0;
    return (s0 < 0) ? s0 + m : s0;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    fraction_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected word found=%0b num=%0d den=%0d", $time,
                   out_ch.found, out_ch.numerator, out_ch.denominator);
          fails++;
        end else begin
          want = pending_q.pop_front();
          if (out_ch.found !== want.found || out_ch.numerator !== want.num ||
              out_ch.denominator !== want.den) begin
            $display("%0t: mismatch expected %0b %0d/%0d actual %0b %0d/%0d", $time,
                     want.found, want.num, want.den,
                     out_ch.found, out_ch.numerator, out_ch.denominator);
            fails++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_left = 2000;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [rru_pkg::CfgIndexWidth-1:0] idx, logic [62:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == rru_pkg::REG_MODULUS) cur_mod = data;
    else cur_bound = data[30:0];
  endtask

  task automatic set_config(logic [62:0] m, logic [30:0] b);
    drain();
    write_reg(rru_pkg::REG_MODULUS, m);
    write_reg(rru_pkg::REG_BOUND, {32'b0, b});
    @(posedge clk);
  endtask

  task automatic send_word(logic [62:0] res, logic typed, fraction_t want);
    while (!steady && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.residue <= res;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.insert(pending_q.size(), typed ? want : reconstruct(res));
  endtask

  row_t rows[$];

  initial begin
    logic [62:0] m, res;
    logic [30:0] b;
    longint n, d, inv, nmod;
    logic [127:0] wide;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.residue = '0;
    cur_mod = 63'd2;
    cur_bound = '0;

    rows = '{
      '{0, 0, 0, 63'd0, 1, '{0, 0, 0}},
      '{0, 0, 0, 63'd1, 1, '{0, 0, 0}},
      '{0, 0, 0, AllOnes, 1, '{0, 0, 0}},
      '{1, 63'd0, 31'd5, 63'h2AAA_5555_0F0F_F0F0, 1, '{0, 0, 0}},
      '{1, 63'd1, 31'd1, 63'd0, 1, '{1, 0, 1}},
      '{0, 0, 0, AllOnes, 1, '{1, 0, 1}},
      '{1, 63'd1, 31'd0, 63'd7, 0, '{0, 0, 0}},
      '{1, ModMax, BoundMax, 63'd0, 1, '{1, 0, 1}},
      '{0, 0, 0, 63'd1, 1, '{1, 1, 1}},
      '{0, 0, 0, ModMax - 63'd1, 1, '{1, -1, 1}},
      '{0, 0, 0, 63'h7FFF_FFFF, 1, '{1, 32'h7FFF_FFFF, 1}},
      '{0, 0, 0, AllOnes, 1, '{1, 0, 1}},
      '{0, 0, 0, 63'h1234_5678_9ABC_DEF0, 0, '{0, 0, 0}},
      '{1, 63'd97, 31'd6, 63'd5, 0, '{0, 0, 0}},
      '{0, 0, 0, 63'd50, 0, '{0, 0, 0}},
      '{0, 0, 0, 63'd96, 0, '{0, 0, 0}},
      '{0, 0, 0, 63'd33, 0, '{0, 0, 0}},
      '{1, 63'd97, BoundMax, 63'd40, 0, '{0, 0, 0}},
      '{1, 63'd1000003, 31'd707, 63'h4000_0000_0000_0000, 0, '{0, 0, 0}},
      '{0, 0, 0, 63'd12345, 0, '{0, 0, 0}}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_cfg) set_config(rows[i].mod_val, rows[i].bound_val);
      send_word(rows[i].residue, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0: m = 63'($urandom_range(1000, 2));
        1: m = {31'b0, $urandom()} | 63'd2;
        2: m = 63'({$urandom(), $urandom()} >> 1);
        default: m = ModMax;
      endcase
      if (m < 2) m = 63'd2;
      case ($urandom_range(7))
        0: b = '0;
        1: b = BoundMax;
        2: b = 31'($urandom() >> 1);
        default: b = ($sqrt(real'(m) / 2.0) >= 2147483647.0) ? BoundMax :
                      31'($rtoi($sqrt(real'(m) / 2.0)));
      endcase
      set_config(m, b);
      steady = (ph == 5);
      for (int k = 0; k < 110; k++) begin
        if (ph == 2 && k == 40) hold_req = 1;
        if (ph == 3 && k == 60) begin
          in_ch.valid <= 1'b0;
          wait (pending_q.size() == 0);
          @(posedge clk);
        end
        res = 63'({$urandom(), $urandom()} >> 1);
        if (b > 0 && $urandom_range(9) < 7) begin
          n = $urandom_range(b);
          if ($urandom_range(1)) n = -n;
          d = $urandom_range(b, 1);
          inv = mod_inverse(d, longint'(m));
          if (inv != 0) begin
            nmod = n % longint'(m);
            if (nmod < 0) nmod += longint'(m);
            wide = 128'(nmod) * 128'(inv);
            res = 63'(wide % {65'b0, m});
          end
        end
        send_word(res, 1'b0, '0);
      end
      steady = 0;
    end

    drain();
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
